// ----- src/per_session_round_robin_event_queue_macros.svh -----
// Assertion macros shared by the event queue RTL.
`ifndef PER_SESSION_ROUND_ROBIN_EVENT_QUEUE_MACROS_SVH
`define PER_SESSION_ROUND_ROBIN_EVENT_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
// A condition that must hold at every clock edge outside reset.
`define PSRQ_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// A consequence that must hold in the same cycle as its trigger.
`define PSRQ_ASSERT_IMPLY(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");
`else
`define PSRQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define PSRQ_ASSERT_IMPLY(label, clk, rst, trig, cond)
`endif

`endif

// ----- src/psrq_pkg.sv -----
// Shared widths, codes and types of the event queue.
package psrq_pkg;

  localparam int OP_W     = 1;
  localparam int KIND_W   = 2;
  localparam int SID_W    = 6;
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0]   OP_PUSH      = 1'b0;
  localparam logic [OP_W-1:0]   OP_POP       = 1'b1;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Lane write enables of the session table.
  typedef struct packed {
    logic ptr;
    logic ring;
  } sess_we_t;

endpackage

// ----- src/psrq_chan_if.sv -----
// Command and response channel interfaces of the event queue.
interface psrq_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [psrq_pkg::OP_W-1:0]     op;
  logic [psrq_pkg::KIND_W-1:0]   event_kind;
  logic [psrq_pkg::SID_W-1:0]    session_id;
  logic [psrq_pkg::PAY_W-1:0]    payload;

  modport source (output valid, op, event_kind, session_id, payload, input ready);
  modport sink (input valid, op, event_kind, session_id, payload, output ready);
endinterface

interface psrq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [psrq_pkg::STATUS_W-1:0] status;
  logic [psrq_pkg::SID_W-1:0]    out_session;
  logic [psrq_pkg::KIND_W-1:0]   out_kind;
  logic [psrq_pkg::PAY_W-1:0]    out_payload;

  modport source (output valid, status, out_session, out_kind, out_payload, input ready);
  modport sink (input valid, status, out_session, out_kind, out_payload, output ready);
endinterface

// ----- src/psrq_evt_mem.sv -----
// Event store: one write port, one registered read port.
module psrq_evt_mem #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 34
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/psrq_sess_mem.sv -----
// Session table: FIFO head and count per session plus the ready ring, with lane write enables.
module psrq_sess_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int PTR_W  = 3,
  parameter int CNT_W  = 4,
  parameter int RING_W = 6
) (
  input  logic               clk,
  input  psrq_pkg::sess_we_t we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [PTR_W-1:0]   whead,
  input  logic [CNT_W-1:0]   wcount,
  input  logic [RING_W-1:0]  wring,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [PTR_W-1:0]   rhead,
  output logic [CNT_W-1:0]   rcount,
  output logic [RING_W-1:0]  rring
);

  localparam int ENT_W = PTR_W + CNT_W + RING_W;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we.ptr) begin
      mem[waddr][RING_W +: PTR_W + CNT_W] <= {whead, wcount};
    end
    if (we.ring) begin
      mem[waddr][RING_W-1:0] <= wring;
    end
    rdata <= mem[raddr];
  end

  assign rhead  = rdata[RING_W + CNT_W +: PTR_W];
  assign rcount = rdata[RING_W +: CNT_W];
  assign rring  = rdata[RING_W-1:0];

endmodule

// ----- src/per_session_round_robin_event_queue.sv -----
// Per-session event FIFOs with a round-robin ready ring of sessions.
// A push passes through S_P1, then S_P2 when it puts its session on the ready
// ring, then S_RES; a pop passes S_Q1, S_Q2 and S_Q3 to S_RES, or goes straight
// to S_RES when no session is ready. The steps are set by the single read and
// single write port of the session table, which each push and each ready pop
// reads, modifies and writes back in turn. Results leave through an output
// register, so the next item is accepted while a result still waits. After
// reset a clearing pass zeroes the session table; no item is accepted during it.
`include "per_session_round_robin_event_queue_macros.svh"

module per_session_round_robin_event_queue #(
  parameter int SESSIONS           = 64,
  parameter int EVENTS_PER_SESSION = 8,
  parameter int PAYLOAD_BITS       = 32
) (
  input logic          clk,
  input logic          rst,
  psrq_cmd_if.sink     cmd,
  psrq_rsp_if.source   rsp
);

  localparam int SW     = $clog2(SESSIONS);
  localparam int SLOT_W = (EVENTS_PER_SESSION > 1) ? $clog2(EVENTS_PER_SESSION) : 1;
  localparam int CNT_W  = $clog2(EVENTS_PER_SESSION + 1);
  localparam int RC_W   = $clog2(SESSIONS + 1);
  localparam int PP_W   = psrq_pkg::PAY_W;
  localparam int SP_W   = psrq_pkg::SID_W;
  localparam int KW     = psrq_pkg::KIND_W;
  localparam int KEEP_W = (PAYLOAD_BITS < PP_W) ? PAYLOAD_BITS : PP_W;
  localparam int EV_W   = KW + KEEP_W;
  localparam int EV_AW  = SW + SLOT_W;

  localparam logic [SW-1:0]     S_LAST  = SW'(SESSIONS - 1);
  localparam logic [SW:0]       S_X     = (SW + 1)'(SESSIONS);
  localparam logic [RC_W-1:0]   S_CNT   = RC_W'(SESSIONS);
  localparam logic [CNT_W-1:0]  EPS_CNT = CNT_W'(EVENTS_PER_SESSION);
  localparam logic [SLOT_W:0]   EPS_X   = (SLOT_W + 1)'(EVENTS_PER_SESSION);
  localparam logic [SLOT_W-1:0] H_LAST  = SLOT_W'(EVENTS_PER_SESSION - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_P1, S_P2, S_Q1, S_Q2, S_Q3, S_RES
  } state_t;

  // Folds a session number into range by restoring subtraction of shifted SESSIONS.
  function automatic logic [SW-1:0] sess_of(input logic [SP_W-1:0] sid);
    int v;
    v = int'(sid);
    for (int k = SP_W - 1; k >= 0; k--) begin
      if (v >= (SESSIONS << k)) begin
        v = v - (SESSIONS << k);
      end
    end
    return SW'(v);
  endfunction

  state_t                state;
  logic [SW-1:0]         clr_idx;
  logic [SW-1:0]         rh;
  logic [RC_W-1:0]       rc;
  logic [SW-1:0]         cur_s;
  logic [KW-1:0]         cur_kind;
  logic [KEEP_W-1:0]     cur_pay;
  logic                  append;
  psrq_pkg::status_t     res_status;
  logic [SW-1:0]         res_sess;
  logic [KW-1:0]         res_kind;
  logic [KEEP_W-1:0]     res_pay;

  logic [SW-1:0]         s_in;
  logic [SW-1:0]         rh_inc;
  logic [SW:0]           tail_sum;
  logic [SW-1:0]         tail;
  logic [SLOT_W:0]       slot_sum;
  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W-1:0]     head_inc;

  psrq_pkg::sess_we_t    sm_we;
  logic [SW-1:0]         sm_waddr;
  logic [SLOT_W-1:0]     sm_whead;
  logic [CNT_W-1:0]      sm_wcount;
  logic [SW-1:0]         sm_wring;
  logic [SW-1:0]         sm_raddr;
  logic [SLOT_W-1:0]     sm_head;
  logic [CNT_W-1:0]      sm_cnt;
  logic [SW-1:0]         sm_ring;

  logic                  ev_we;
  logic [EV_AW-1:0]      ev_waddr;
  logic [EV_W-1:0]       ev_wdata;
  logic [EV_AW-1:0]      ev_raddr;
  logic [EV_W-1:0]       ev_rdata;

  psrq_sess_mem #(
    .DEPTH  (SESSIONS),
    .ADDR_W (SW),
    .PTR_W  (SLOT_W),
    .CNT_W  (CNT_W),
    .RING_W (SW)
  ) u_sess (
    .clk    (clk),
    .we     (sm_we),
    .waddr  (sm_waddr),
    .whead  (sm_whead),
    .wcount (sm_wcount),
    .wring  (sm_wring),
    .raddr  (sm_raddr),
    .rhead  (sm_head),
    .rcount (sm_cnt),
    .rring  (sm_ring)
  );

  psrq_evt_mem #(
    .ADDR_W (EV_AW),
    .DATA_W (EV_W)
  ) u_evt (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  assign s_in = (cmd.event_kind == psrq_pkg::KIND_UNKNOWN) ? '0 : sess_of(cmd.session_id);
  assign rh_inc = (rh == S_LAST) ? '0 : rh + 1'b1;

  // The ring tail sits rc places past the head, wrapped once.
  assign tail_sum = (SW + 1)'(rh) + (SW + 1)'(rc);
  assign tail     = (tail_sum >= S_X) ? SW'(tail_sum - S_X) : SW'(tail_sum);

  assign slot_sum = (SLOT_W + 1)'(sm_head) + (SLOT_W + 1)'(sm_cnt);
  assign slot     = (slot_sum >= EPS_X) ? SLOT_W'(slot_sum - EPS_X) : SLOT_W'(slot_sum);
  assign head_inc = (sm_head == H_LAST) ? '0 : sm_head + 1'b1;

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    sm_we     = '0;
    sm_waddr  = cur_s;
    sm_whead  = sm_head;
    sm_wcount = sm_cnt;
    sm_wring  = cur_s;
    sm_raddr  = cur_s;
    ev_we     = 1'b0;
    ev_waddr  = {cur_s, slot};
    ev_wdata  = {cur_kind, cur_pay};
    ev_raddr  = {cur_s, sm_head};
    case (state)
      S_CLEAR: begin
        sm_we     = '{ptr: 1'b1, ring: 1'b1};
        sm_waddr  = clr_idx;
        sm_whead  = '0;
        sm_wcount = '0;
        sm_wring  = '0;
      end
      S_IDLE: begin
        sm_raddr = (cmd.op == psrq_pkg::OP_PUSH) ? s_in : rh;
      end
      S_P1: begin
        if (sm_cnt < EPS_CNT) begin
          sm_we.ptr = 1'b1;
          sm_wcount = sm_cnt + 1'b1;
          ev_we     = 1'b1;
        end
      end
      S_P2: begin
        sm_we.ring = 1'b1;
        sm_waddr   = tail;
      end
      S_Q1: begin
        sm_raddr = sm_ring;
      end
      S_Q2: begin
        if (sm_cnt != '0) begin
          sm_we.ptr = 1'b1;
          sm_whead  = head_inc;
          sm_wcount = sm_cnt - 1'b1;
        end
      end
      S_Q3: begin
        sm_we.ring = append;
        sm_waddr   = tail;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rh        <= '0;
      rc        <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // In S_RES the result register is reloaded below instead.
      if (rsp.valid && rsp.ready && state != S_RES) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == S_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            cur_kind <= cmd.event_kind;
            cur_pay  <= cmd.payload[KEEP_W-1:0];
            cur_s    <= s_in;
            if (cmd.op == psrq_pkg::OP_PUSH) begin
              state <= S_P1;
            end else if (rc == '0) begin
              res_status <= psrq_pkg::ST_EMPTY;
              res_sess   <= '0;
              res_kind   <= '0;
              res_pay    <= '0;
              state      <= S_RES;
            end else begin
              rh    <= rh_inc;
              rc    <= rc - 1'b1;
              state <= S_Q1;
            end
          end
        end
        S_P1: begin
          res_sess <= cur_s;
          res_kind <= cur_kind;
          res_pay  <= '0;
          if (sm_cnt >= EPS_CNT) begin
            res_status <= psrq_pkg::ST_DROPPED;
            state      <= S_RES;
          end else begin
            res_status <= psrq_pkg::ST_ACCEPTED;
            state      <= (sm_cnt == '0 && rc < S_CNT) ? S_P2 : S_RES;
          end
        end
        S_P2: begin
          rc    <= rc + 1'b1;
          state <= S_RES;
        end
        S_Q1: begin
          cur_s <= sm_ring;
          state <= S_Q2;
        end
        S_Q2: begin
          if (sm_cnt == '0) begin
            res_status <= psrq_pkg::ST_EMPTY;
            res_sess   <= '0;
            res_kind   <= '0;
            res_pay    <= '0;
            state      <= S_RES;
          end else begin
            append <= (sm_cnt > CNT_W'(1)) && (rc < S_CNT);
            state  <= S_Q3;
          end
        end
        S_Q3: begin
          res_status <= psrq_pkg::ST_DELIVERED;
          res_sess   <= cur_s;
          res_kind   <= ev_rdata[EV_W-1 -: KW];
          res_pay    <= ev_rdata[KEEP_W-1:0];
          if (append) begin
            rc <= rc + 1'b1;
          end
          state <= S_RES;
        end
        S_RES: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.out_session <= SP_W'(res_sess);
            rsp.out_kind    <= res_kind;
            rsp.out_payload <= PP_W'(res_pay);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PSRQ_ASSERT_ALWAYS(a_ring_bound, clk, rst, rc <= S_CNT)
  `PSRQ_ASSERT_IMPLY(a_ready_has_events, clk, rst, state == S_Q2, sm_cnt != '0)
  `PSRQ_ASSERT_IMPLY(a_count_bound, clk, rst, state == S_P1 || state == S_Q2, sm_cnt <= EPS_CNT)
  `PSRQ_ASSERT_IMPLY(a_empty_zero, clk, rst,
    rsp.valid && rsp.status == psrq_pkg::ST_EMPTY,
    rsp.out_payload == '0 && rsp.out_session == '0 && rsp.out_kind == '0)

endmodule
